>>> rtl/core/rrqm_pkg.sv
// Shared constants for the three-queue round-robin multiplexer.
package rrqm_pkg;

  localparam int NUM_QUEUES          = 3;
  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int DATA_W              = 32;
  localparam int TAG_W               = 8;
  localparam int STATUS_W            = 2;
  localparam int SEL_W               = 2;
  localparam int CFG_ADDR_W          = 4;
  localparam int CFG_DATA_W          = 32;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PUSH_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DELIVERED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // Register indexes (word address)
  localparam logic [1:0] REG_TAG0 = 2'd0;
  localparam logic [1:0] REG_TAG1 = 2'd1;
  localparam logic [1:0] REG_TAG2 = 2'd2;

  // Tag reset values
  localparam logic [TAG_W-1:0] TAG0_RESET = 8'd1;
  localparam logic [TAG_W-1:0] TAG1_RESET = 8'd2;
  localparam logic [TAG_W-1:0] TAG2_RESET = 8'd3;

endpackage

>>> rtl/core/three_queue_round_robin_mux.sv
// Three FIFO queues merged onto one output channel in round-robin order.
//
// Each input beat is a push (append in_push_value to queue in_queue_select) or
// a pull (deliver the head of the next non-empty queue after the last one
// served, tagged with that queue's configured id). While in_ready is high one
// beat is accepted per cycle, its result registered in the output register; the
// queue data lives in one single-port-write memory of 3*QUEUE_DEPTH words
// whose registered read port supplies the delivered value. in_ready drops
// only while a result waits that out_ready does not take. Pushes to a full
// queue or to queue select three are refused; a pull with all queues empty
// reports empty and leaves the round-robin pointer alone. Tag registers sit
// at byte addresses 0, 4 and 8 and reset to 1, 2 and 3.
module three_queue_round_robin_mux #(
  parameter int QUEUE_DEPTH = rrqm_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [rrqm_pkg::SEL_W-1:0]          in_queue_select,
  input  logic signed [rrqm_pkg::DATA_W-1:0]  in_push_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rrqm_pkg::STATUS_W-1:0]       out_status,
  output logic [rrqm_pkg::TAG_W-1:0]          out_tag,
  output logic signed [rrqm_pkg::DATA_W-1:0]  out_value,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rrqm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [rrqm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [rrqm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int NQ     = rrqm_pkg::NUM_QUEUES;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SUM_W  = CNT_W + 1;
  localparam int ADDR_W = $clog2(NQ * QUEUE_DEPTH);
  localparam int QIDX_W = 2;

  // ---------------------------------------------------------------- config
  logic [rrqm_pkg::TAG_W-1:0] tag_r [NQ];
  logic                       cfg_wr;
  logic [1:0]                 cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= rrqm_pkg::TAG0_RESET;
      tag_r[1] <= rrqm_pkg::TAG1_RESET;
      tag_r[2] <= rrqm_pkg::TAG2_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rrqm_pkg::REG_TAG0: tag_r[0] <= pwdata[rrqm_pkg::TAG_W-1:0];
        rrqm_pkg::REG_TAG1: tag_r[1] <= pwdata[rrqm_pkg::TAG_W-1:0];
        rrqm_pkg::REG_TAG2: tag_r[2] <= pwdata[rrqm_pkg::TAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      rrqm_pkg::REG_TAG0: prdata[rrqm_pkg::TAG_W-1:0] = tag_r[0];
      rrqm_pkg::REG_TAG1: prdata[rrqm_pkg::TAG_W-1:0] = tag_r[1];
      rrqm_pkg::REG_TAG2: prdata[rrqm_pkg::TAG_W-1:0] = tag_r[2];
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- queue state
  logic [CNT_W-1:0]  fill_r [NQ];
  logic [PTR_W-1:0]  head_r [NQ];
  logic [QIDX_W-1:0] nts_r;

  logic signed [rrqm_pkg::DATA_W-1:0] mem [NQ * QUEUE_DEPTH];
  logic signed [rrqm_pkg::DATA_W-1:0] rd_data_r;

  logic                               out_valid_r;
  logic [rrqm_pkg::STATUS_W-1:0]      out_status_r;
  logic [rrqm_pkg::TAG_W-1:0]         out_tag_r;
  logic                               out_from_mem_r;

  logic              in_fire;
  logic              sel_ok;
  logic [QIDX_W-1:0] push_q;
  logic              push_ok;
  logic [SUM_W-1:0]  slot_sum;
  logic [PTR_W-1:0]  push_slot;
  logic [ADDR_W-1:0] wr_addr;

  logic [NQ-1:0]     not_empty;
  logic              pull_hit;
  logic [QIDX_W-1:0] pull_q;
  logic [QIDX_W:0]   cand_sum;
  logic [QIDX_W-1:0] cand_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [PTR_W-1:0]  head_inc;
  logic [QIDX_W-1:0] nts_nxt;
  logic [rrqm_pkg::TAG_W-1:0] pull_tag;

  logic [rrqm_pkg::STATUS_W-1:0] status_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // push side
  assign sel_ok  = in_queue_select < QIDX_W'(NQ);
  assign push_q  = sel_ok ? in_queue_select : '0;
  assign push_ok = sel_ok && (fill_r[push_q] < CNT_W'(QUEUE_DEPTH));

  assign slot_sum  = SUM_W'(head_r[push_q]) + SUM_W'(fill_r[push_q]);
  assign push_slot = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     PTR_W'(slot_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(slot_sum);
  assign wr_addr   = ADDR_W'(push_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(push_slot);

  // pull side: first non-empty queue starting at the pointer
  always_comb begin
    pull_hit = 1'b0;
    pull_q   = '0;
    cand_sum = '0;
    cand_q   = '0;
    for (int i = 0; i < NQ; i++) begin
      not_empty[i] = fill_r[i] != '0;
    end
    for (int k = 0; k < NQ; k++) begin
      cand_sum = (QIDX_W + 1)'(nts_r) + (QIDX_W + 1)'(k);
      cand_q   = (cand_sum >= (QIDX_W + 1)'(NQ)) ?
                 QIDX_W'(cand_sum - (QIDX_W + 1)'(NQ)) : QIDX_W'(cand_sum);
      if (!pull_hit && not_empty[cand_q]) begin
        pull_hit = 1'b1;
        pull_q   = cand_q;
      end
    end
  end

  assign rd_addr  = ADDR_W'(pull_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_r[pull_q]);
  assign head_inc = (head_r[pull_q] == PTR_W'(QUEUE_DEPTH - 1)) ?
                    '0 : head_r[pull_q] + PTR_W'(1);
  assign nts_nxt  = (pull_q == QIDX_W'(NQ - 1)) ? '0 : pull_q + QIDX_W'(1);
  assign pull_tag = tag_r[pull_q];

  always_comb begin
    if (in_cmd == rrqm_pkg::CMD_PUSH) begin
      status_nxt = push_ok ? rrqm_pkg::ST_PUSH_OK : rrqm_pkg::ST_PUSH_FULL;
    end else begin
      status_nxt = pull_hit ? rrqm_pkg::ST_DELIVERED : rrqm_pkg::ST_EMPTY;
    end
  end

  // queue bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NQ; i++) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
      end
      nts_r <= '0;
    end else if (in_fire) begin
      if (in_cmd == rrqm_pkg::CMD_PUSH) begin
        if (push_ok) begin
          fill_r[push_q] <= fill_r[push_q] + CNT_W'(1);
        end
      end else if (pull_hit) begin
        fill_r[pull_q] <= fill_r[pull_q] - CNT_W'(1);
        head_r[pull_q] <= head_inc;
        nts_r          <= nts_nxt;
      end
    end
  end

  // data memory
  always_ff @(posedge clk) begin
    if (in_fire && (in_cmd == rrqm_pkg::CMD_PUSH) && push_ok) begin
      mem[wr_addr] <= in_push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_cmd == rrqm_pkg::CMD_PULL) && pull_hit) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r   <= status_nxt;
      out_from_mem_r <= (in_cmd == rrqm_pkg::CMD_PULL) && pull_hit;
      out_tag_r      <= ((in_cmd == rrqm_pkg::CMD_PULL) && pull_hit) ? pull_tag : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_tag    = out_tag_r;
  assign out_value  = out_from_mem_r ? rd_data_r : '0;

  // ---------------------------------------------------------------- checks
  a_no_payload_unless_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != rrqm_pkg::ST_DELIVERED) |-> (out_value == '0) && (out_tag == '0))
    else $error("payload on a result that delivers nothing");

  a_empty_pull_reports_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_cmd == rrqm_pkg::CMD_PULL) && (not_empty == '0)
      |=> out_valid && (out_status == rrqm_pkg::ST_EMPTY))
    else $error("pull with all queues empty did not report empty");

  a_full_push_holds_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_cmd == rrqm_pkg::CMD_PUSH) && !push_ok
      |=> $stable(fill_r[0]) && $stable(fill_r[1]) && $stable(fill_r[2]))
    else $error("refused push changed a queue fill");

  a_pointer_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> nts_r < QIDX_W'(NQ))
    else $error("round-robin pointer out of range");

  a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

endmodule
